// ===== src/tpbc_pkg.sv =====
// ----------------------------------------------------------------------------
// tpbc_pkg
// Shared types, constants and the CORDIC angle table of the tilt balance
// controller.
// ----------------------------------------------------------------------------
package tpbc_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ACC_W        = 48;
    localparam int MUL_CYC      = 20;
    localparam int CNT_W        = 6;

    localparam logic signed [26:0] HALF_TURN = 27'sd11796480;

    localparam logic [19:0] DIV_RATE = 20'd2096;
    localparam logic [19:0] DIV_US   = 20'd1000000;
    localparam logic [19:0] DIV_FILT = 20'd65536;

    localparam logic [2:0] REG_GYRO_OFFSET    = 3'd0;
    localparam logic [2:0] REG_ANGLE_SETPOINT = 3'd1;
    localparam logic [2:0] REG_GAIN_P         = 3'd2;
    localparam logic [2:0] REG_GAIN_I         = 3'd3;
    localparam logic [2:0] REG_GAIN_D         = 3'd4;
    localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd5;
    localparam logic [2:0] REG_DEAD_ZONE      = 3'd6;
    localparam logic [2:0] REG_FILTER_ALPHA   = 3'd7;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CINIT,
        S_CORD,
        S_CEND,
        S_RATE,
        S_INC0,
        S_INC1,
        S_TLT0,
        S_TLT1,
        S_TLT2,
        S_ERR0,
        S_ERR1,
        S_INT,
        S_SUM1,
        S_SUM2,
        S_OUT,
        S_MUL,
        S_DIV
    } t_state;

    // atan(2^-i) in degrees, Q20 source table rounded to Q16
    function automatic logic signed [26:0] atan_entry(input logic [4:0] idx);
        logic [31:0] t;
        unique case (idx)
            5'd0:    t = 32'd47185920;
            5'd1:    t = 32'd27855475;
            5'd2:    t = 32'd14718068;
            5'd3:    t = 32'd7471121;
            5'd4:    t = 32'd3750058;
            5'd5:    t = 32'd1876857;
            5'd6:    t = 32'd938658;
            5'd7:    t = 32'd469357;
            5'd8:    t = 32'd234682;
            5'd9:    t = 32'd117342;
            5'd10:   t = 32'd58671;
            5'd11:   t = 32'd29335;
            5'd12:   t = 32'd14668;
            5'd13:   t = 32'd7334;
            5'd14:   t = 32'd3667;
            5'd15:   t = 32'd1833;
            5'd16:   t = 32'd917;
            5'd17:   t = 32'd458;
            5'd18:   t = 32'd229;
            5'd19:   t = 32'd115;
            5'd20:   t = 32'd57;
            5'd21:   t = 32'd29;
            5'd22:   t = 32'd14;
            5'd23:   t = 32'd7;
            default: t = 32'd0;
        endcase
        t = (t + 32'd8) >> 4;
        return $signed(t[26:0]);
    endfunction

endpackage

// ===== src/tilt_pid_balance_controller.sv =====
// ----------------------------------------------------------------------------
// tilt_pid_balance_controller
// Complementary-filter tilt estimate with PID motor drive, built around a
// shared bit-serial multiply-accumulate and a bit-serial constant divider.
// ----------------------------------------------------------------------------
// Sequencing: the seeding sample returns to o_ready with no result; every later
// sample raises o_valid when done, o_ready with it. A new sample is taken only
// in idle, once the last one is through: 4 serial divides and 7 serial
// multiply-adds, and the output step waits while an untaken result is held.
// Reset (i_rst_n low, synchronous): registers to defaults, angle, integral
// and seeded flag cleared.
module tilt_pid_balance_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_gyro_y,
    input  logic        [19:0] i_elapsed_us,
    output logic               o_valid,
    input  logic               i_ready,
    output logic        [15:0] o_motor_power,
    output logic               o_reverse,
    output logic signed [24:0] o_tilt_angle,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [4:0]  paddr,
    input  logic        [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready
);

    // configuration
    logic signed [19:0] r_goff;
    logic signed [24:0] r_sp;
    logic        [15:0] r_gp;
    logic        [15:0] r_gi;
    logic        [11:0] r_gd;
    logic        [22:0] r_ilim;
    logic        [15:0] r_dz;
    logic        [16:0] r_alpha;

    // control and filter state
    tpbc_pkg::t_state r_state, n_state, r_ret, n_ret;
    logic [tpbc_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic               r_seeded, n_seeded;
    logic signed [24:0] r_filt, n_filt;
    logic signed [23:0] r_integ, n_integ;
    logic               r_ovalid, n_ovalid;

    // datapath
    logic signed [15:0] r_ax, n_ax, r_az, n_az, r_g, n_g;
    logic        [19:0] r_us, n_us;
    logic signed [26:0] r_cx, n_cx, r_cy, n_cy, r_cz, n_cz;
    logic signed [25:0] r_atilt, n_atilt;
    logic signed [26:0] r_rate, n_rate;
    logic signed [26:0] r_err, n_err;
    logic signed [tpbc_pkg::ACC_W-1:0] r_acc, n_acc, r_ma, n_ma;
    logic        [19:0] r_mb, n_mb;
    logic        [tpbc_pkg::ACC_W-1:0] r_quo, n_quo;
    logic        [19:0] r_rem, n_rem;
    logic        [19:0] r_div, n_div;
    logic               r_neg, n_neg;
    logic        [15:0] r_power, n_power;
    logic               r_rev, n_rev;
    logic signed [24:0] r_tout, n_tout;

    // combinational helpers
    logic signed [21:0] rate_num;
    logic signed [tpbc_pkg::ACC_W-1:0] div_src, div_res;
    logic        [tpbc_pkg::ACC_W-1:0] div_mag, quo_next, pmag;
    logic        [20:0] rem_try;
    logic               rem_ge;
    logic        [16:0] alpha_sat;
    logic signed [26:0] dx, dy, tab, x0, y0;
    logic        [4:0]  cidx;
    logic signed [25:0] tilt_c;
    logic signed [27:0] filt_inc, integ_sum, lim;
    logic        [15:0] psat;
    logic               cfg_wr;

    assign o_ready       = (r_state == tpbc_pkg::S_IDLE);
    assign o_valid       = r_ovalid;
    assign o_motor_power = r_power;
    assign o_reverse     = r_rev;
    assign o_tilt_angle  = r_tout;
    assign pready        = 1'b1;
    assign cfg_wr        = psel & penable & pwrite & pready;

    always_comb begin
        unique case (paddr[4:2])
            tpbc_pkg::REG_GYRO_OFFSET:    prdata = {{12{r_goff[19]}}, r_goff};
            tpbc_pkg::REG_ANGLE_SETPOINT: prdata = {{7{r_sp[24]}}, r_sp};
            tpbc_pkg::REG_GAIN_P:         prdata = {16'd0, r_gp};
            tpbc_pkg::REG_GAIN_I:         prdata = {16'd0, r_gi};
            tpbc_pkg::REG_GAIN_D:         prdata = {20'd0, r_gd};
            tpbc_pkg::REG_INTEGRAL_LIMIT: prdata = {9'd0, r_ilim};
            tpbc_pkg::REG_DEAD_ZONE:      prdata = {16'd0, r_dz};
            tpbc_pkg::REG_FILTER_ALPHA:   prdata = {15'd0, r_alpha};
            default:                      prdata = 32'd0;
        endcase
    end

    // (gyro*16 - offset), scaled by 2^16 before the divide
    assign rate_num  = {r_g[15], r_g[15], r_g, 4'd0} - {{2{r_goff[19]}}, r_goff};
    assign div_src   = (r_state == tpbc_pkg::S_RATE) ?
                       {{10{rate_num[21]}}, rate_num, 16'd0} : r_acc;
    assign div_mag   = div_src[tpbc_pkg::ACC_W-1] ? 48'(-div_src) : 48'(div_src);
    assign rem_try   = {r_rem, r_quo[tpbc_pkg::ACC_W-1]};
    assign rem_ge    = (rem_try >= {1'b0, r_div});
    assign quo_next  = {r_quo[tpbc_pkg::ACC_W-2:0], rem_ge};
    assign div_res   = r_neg ? $signed(48'(-quo_next)) : $signed(quo_next);

    assign alpha_sat = (r_alpha > 17'd65536) ? 17'd65536 : r_alpha;

    assign cidx = r_cnt[4:0];
    assign dx   = r_cx >>> cidx;
    assign dy   = r_cy >>> cidx;
    assign tab  = tpbc_pkg::atan_entry(cidx);
    assign x0   = {{3{r_ax[15]}}, r_ax, 8'd0};
    assign y0   = {{3{r_az[15]}}, r_az, 8'd0};

    assign tilt_c = (r_acc > 48'sd11796480) ? 26'sd11796480 :
                    (r_acc < -48'sd11796480) ? -26'sd11796480 : r_acc[25:0];
    assign filt_inc  = {{3{r_filt[24]}}, r_filt} + {r_acc[26], r_acc[26:0]};
    assign integ_sum = {{4{r_integ[23]}}, r_integ} + r_acc[27:0];
    assign lim       = {5'd0, r_ilim};

    assign pmag = r_acc[tpbc_pkg::ACC_W-1] ? 48'(-r_acc) : 48'(r_acc);
    assign psat = (|pmag[47:32]) ? 16'hFFFF : pmag[31:16];

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_cnt    = r_cnt;
        n_seeded = r_seeded;
        n_filt   = r_filt;
        n_integ  = r_integ;
        n_ovalid = r_ovalid & ~i_ready;
        n_ax     = r_ax;
        n_az     = r_az;
        n_g      = r_g;
        n_us     = r_us;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_cz     = r_cz;
        n_atilt  = r_atilt;
        n_rate   = r_rate;
        n_err    = r_err;
        n_acc    = r_acc;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_div    = r_div;
        n_neg    = r_neg;
        n_power  = r_power;
        n_rev    = r_rev;
        n_tout   = r_tout;

        unique case (r_state)
            tpbc_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_ax    = i_accel_x;
                    n_az    = i_accel_z;
                    n_g     = i_gyro_y;
                    n_us    = i_elapsed_us;
                    n_state = tpbc_pkg::S_CINIT;
                end
            end
            tpbc_pkg::S_CINIT: begin
                n_cnt = '0;
                if (r_ax == 16'sd0 && r_az == 16'sd0) begin
                    n_cz    = '0;
                    n_state = tpbc_pkg::S_CEND;
                end else if (r_ax[15]) begin
                    n_cx    = -x0;
                    n_cy    = -y0;
                    n_cz    = r_az[15] ? -tpbc_pkg::HALF_TURN : tpbc_pkg::HALF_TURN;
                    n_state = tpbc_pkg::S_CORD;
                end else begin
                    n_cx    = x0;
                    n_cy    = y0;
                    n_cz    = '0;
                    n_state = tpbc_pkg::S_CORD;
                end
            end
            tpbc_pkg::S_CORD: begin
                if (!r_cy[26]) begin
                    n_cx = r_cx + dy;
                    n_cy = r_cy - dx;
                    n_cz = r_cz + tab;
                end else begin
                    n_cx = r_cx - dy;
                    n_cy = r_cy + dx;
                    n_cz = r_cz - tab;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 6'(tpbc_pkg::CORDIC_STEPS - 1)) begin
                    n_state = tpbc_pkg::S_CEND;
                end
            end
            tpbc_pkg::S_CEND: begin
                n_atilt = (r_cz > tpbc_pkg::HALF_TURN) ? 26'sd11796480 :
                          (r_cz < -tpbc_pkg::HALF_TURN) ? -26'sd11796480 : r_cz[25:0];
                if (!r_seeded) begin
                    n_filt   = n_atilt[24:0];
                    n_seeded = 1'b1;
                    n_state  = tpbc_pkg::S_IDLE;
                end else begin
                    n_state = tpbc_pkg::S_RATE;
                end
            end
            tpbc_pkg::S_RATE, tpbc_pkg::S_INC1, tpbc_pkg::S_TLT2, tpbc_pkg::S_ERR1: begin
                // start a rounded divide of the accumulator (in S_RATE, of the gyro rate) by a constant
                priority case (r_state)
                    tpbc_pkg::S_RATE: begin
                        n_div = tpbc_pkg::DIV_RATE;
                        n_ret = tpbc_pkg::S_INC0;
                    end
                    tpbc_pkg::S_INC1: begin
                        n_div = tpbc_pkg::DIV_US;
                        n_ret = tpbc_pkg::S_TLT0;
                    end
                    tpbc_pkg::S_TLT2: begin
                        n_div = tpbc_pkg::DIV_FILT;
                        n_ret = tpbc_pkg::S_ERR0;
                    end
                    default: begin
                        n_div = tpbc_pkg::DIV_US;
                        n_ret = tpbc_pkg::S_INT;
                    end
                endcase
                n_quo   = div_mag + {29'd0, n_div[19:1]};
                n_neg   = div_src[tpbc_pkg::ACC_W-1];
                n_rem   = '0;
                n_cnt   = '0;
                n_state = tpbc_pkg::S_DIV;
            end
            tpbc_pkg::S_DIV: begin
                n_rem = rem_ge ? 20'(rem_try - {1'b0, r_div}) : rem_try[19:0];
                n_quo = quo_next;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 6'(tpbc_pkg::ACC_W - 1)) begin
                    n_acc   = div_res;
                    n_state = r_ret;
                end
            end
            tpbc_pkg::S_MUL: begin
                if (r_mb[0]) begin
                    n_acc = r_acc + r_ma;
                end
                n_ma  = r_ma <<< 1;
                n_mb  = r_mb >> 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 6'(tpbc_pkg::MUL_CYC - 1)) begin
                    n_state = r_ret;
                end
            end
            tpbc_pkg::S_INC0: begin
                n_rate  = r_acc[26:0];
                n_acc   = '0;
                n_ma    = {{21{r_acc[26]}}, r_acc[26:0]};
                n_mb    = r_us;
                n_cnt   = '0;
                n_ret   = tpbc_pkg::S_INC1;
                n_state = tpbc_pkg::S_MUL;
            end
            tpbc_pkg::S_TLT0: begin
                n_acc   = '0;
                n_ma    = {{20{filt_inc[27]}}, filt_inc};
                n_mb    = {3'd0, alpha_sat};
                n_cnt   = '0;
                n_ret   = tpbc_pkg::S_TLT1;
                n_state = tpbc_pkg::S_MUL;
            end
            tpbc_pkg::S_TLT1: begin
                n_ma    = {{22{r_atilt[25]}}, r_atilt};
                n_mb    = {3'd0, 17'(17'd65536 - alpha_sat)};
                n_cnt   = '0;
                n_ret   = tpbc_pkg::S_TLT2;
                n_state = tpbc_pkg::S_MUL;
            end
            tpbc_pkg::S_ERR0: begin
                n_filt  = tilt_c[24:0];
                n_err   = {tilt_c[25], tilt_c} - {{2{r_sp[24]}}, r_sp};
                n_acc   = '0;
                n_ma    = {{21{n_err[26]}}, n_err};
                n_mb    = r_us;
                n_cnt   = '0;
                n_ret   = tpbc_pkg::S_ERR1;
                n_state = tpbc_pkg::S_MUL;
            end
            tpbc_pkg::S_INT: begin
                if (integ_sum > lim) begin
                    n_integ = lim[23:0];
                end else if (integ_sum < -lim) begin
                    n_integ = 24'(-lim);
                end else begin
                    n_integ = integ_sum[23:0];
                end
                n_acc   = '0;
                n_ma    = {{21{r_err[26]}}, r_err};
                n_mb    = {4'd0, r_gp};
                n_cnt   = '0;
                n_ret   = tpbc_pkg::S_SUM1;
                n_state = tpbc_pkg::S_MUL;
            end
            tpbc_pkg::S_SUM1: begin
                n_ma    = {{24{r_integ[23]}}, r_integ};
                n_mb    = {4'd0, r_gi};
                n_cnt   = '0;
                n_ret   = tpbc_pkg::S_SUM2;
                n_state = tpbc_pkg::S_MUL;
            end
            tpbc_pkg::S_SUM2: begin
                n_ma    = {{21{r_rate[26]}}, r_rate};
                n_mb    = {8'd0, r_gd};
                n_cnt   = '0;
                n_ret   = tpbc_pkg::S_OUT;
                n_state = tpbc_pkg::S_MUL;
            end
            tpbc_pkg::S_OUT: begin
                // hold until the output register is free
                if (!r_ovalid || i_ready) begin
                    n_power  = (psat < r_dz) ? 16'd0 : psat;
                    n_rev    = r_acc[tpbc_pkg::ACC_W-1] | (r_acc == '0);
                    n_tout   = r_filt;
                    n_ovalid = 1'b1;
                    n_state  = tpbc_pkg::S_IDLE;
                end
            end
            default: n_state = tpbc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tpbc_pkg::S_IDLE;
            r_ret    <= tpbc_pkg::S_IDLE;
            r_cnt    <= '0;
            r_seeded <= 1'b0;
            r_filt   <= '0;
            r_integ  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_cnt    <= n_cnt;
            r_seeded <= n_seeded;
            r_filt   <= n_filt;
            r_integ  <= n_integ;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ax    <= n_ax;
        r_az    <= n_az;
        r_g     <= n_g;
        r_us    <= n_us;
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        r_cz    <= n_cz;
        r_atilt <= n_atilt;
        r_rate  <= n_rate;
        r_err   <= n_err;
        r_acc   <= n_acc;
        r_ma    <= n_ma;
        r_mb    <= n_mb;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_div   <= n_div;
        r_neg   <= n_neg;
        r_power <= n_power;
        r_rev   <= n_rev;
        r_tout  <= n_tout;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goff  <= 20'sd0;
            r_sp    <= -25'sd511181;
            r_gp    <= 16'd15000;
            r_gi    <= 16'd1000;
            r_gd    <= 12'd220;
            r_ilim  <= 23'd655360;
            r_dz    <= 16'd6000;
            r_alpha <= 17'd64225;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                tpbc_pkg::REG_GYRO_OFFSET:    r_goff  <= pwdata[19:0];
                tpbc_pkg::REG_ANGLE_SETPOINT: r_sp    <= pwdata[24:0];
                tpbc_pkg::REG_GAIN_P:         r_gp    <= pwdata[15:0];
                tpbc_pkg::REG_GAIN_I:         r_gi    <= pwdata[15:0];
                tpbc_pkg::REG_GAIN_D:         r_gd    <= pwdata[11:0];
                tpbc_pkg::REG_INTEGRAL_LIMIT: r_ilim  <= pwdata[22:0];
                tpbc_pkg::REG_DEAD_ZONE:      r_dz    <= pwdata[15:0];
                tpbc_pkg::REG_FILTER_ALPHA:   r_alpha <= pwdata[16:0];
                default:                      r_goff  <= r_goff;
            endcase
        end
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == tpbc_pkg::S_CINIT))
        else $error("accepted transaction did not start the sequence");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == tpbc_pkg::S_OUT))
        else $error("result appeared outside the output step");

    a_dead_zone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_motor_power != 16'd0)) |-> (o_motor_power >= r_dz))
        else $error("motor power below dead zone");

endmodule
